FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, off while reset is held
`define SLLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked property, live during reset as well
`define SLLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: design/sllm_pkg.sv
// package: widths, codes and types of the linked list manager
`timescale 1ns / 1ps

package sllm_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int OP_W        = 2;
    localparam int POS_W       = 7;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 3;
    localparam int MAX_RESULTS = 64;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD  = 2'd0,
        OP_DEL_AFTER = 2'd1,
        OP_INS_AFTER = 2'd2,
        OP_TRAVERSE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_BAD_POS = 3'd2,
        ST_NO_SUCC = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // enables from the sequencer to the node store
    typedef struct packed {
        logic rd_en;
        logic lnk_we;
        logic val_we;
    } t_mem_ctl;

endpackage

FILE: design/sllm_if.sv
// stream interfaces for command beats and result beats
`timescale 1ns / 1ps

interface sllm_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [sllm_pkg::OP_W-1:0]            operation;
    logic [sllm_pkg::POS_W-1:0]           position;
    logic signed [sllm_pkg::VAL_W-1:0]    value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface sllm_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sllm_pkg::VAL_W-1:0]    item_value;
    logic                                 last;
    logic [sllm_pkg::STAT_W-1:0]          status;

    modport source (output valid, output item_value, output last, output status,
                    input ready);
    modport sink   (input valid, input item_value, input last, input status,
                    output ready);
endinterface

FILE: design/sllm_store.sv
// node store: value memory and link memory, one shared read address
`timescale 1ns / 1ps

module sllm_store #(
    parameter int DEPTH = sllm_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  sllm_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]      i_lnk_waddr,
    input  logic [$clog2(DEPTH):0]        i_lnk_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_val_waddr,
    input  logic [sllm_pkg::VAL_W-1:0]    i_val_wdata,
    output logic [$clog2(DEPTH):0]        o_rd_link,
    output logic [sllm_pkg::VAL_W-1:0]    o_rd_val
);

    localparam int LINK_W = $clog2(DEPTH) + 1;

    logic [LINK_W-1:0]         r_links [DEPTH];
    logic [sllm_pkg::VAL_W-1:0] r_vals [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.lnk_we) begin
            r_links[i_lnk_waddr] <= i_lnk_wdata;
        end
        if (i_ctl.rd_en) begin
            o_rd_link <= r_links[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            r_vals[i_val_waddr] <= i_val_wdata;
        end
        if (i_ctl.rd_en) begin
            o_rd_val <= r_vals[i_rd_addr];
        end
    end

endmodule

FILE: design/static_linked_list_manager.sv
// top level: singly linked list kept in a static node store
`timescale 1ns / 1ps
// usage
//   i_cmd carries one command beat: operation, position k and value. o_res
//   carries result beats: item_value, last and status. every command gives
//   at least one result beat, and the final one carries last = 1.
// sequence per command (from accepted command to its last beat)
//   insert at head : new node written at the head as its beat is issued
//   delete         : the successor's link is read first when it has to be bypassed
//   insert after k : new node written, then the k-th link patched
//   traverse       : one node per cycle while the result side is not stalled, set by
//                    the single read port of the node store (at most 64 beats)
//   rejected       : a status beat only, nothing written
//   the next command is taken once the previous one has issued its last beat
//   to the output register, so the command side keeps moving while that beat
//   waits to be taken.
// reset
//   the list is empty and no slot is in use; store contents are not cleared,
//   slots only become reachable once written.
// back-pressure
//   a stalled result side holds the sequencer at each step that issues a beat; nothing is dropped.
`include "assert_macros.svh"

module static_linked_list_manager #(
    parameter int DEPTH = sllm_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sllm_cmd_if.sink    i_cmd,
    sllm_res_if.source  o_res
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int LINK_W = IDX_W + 1;            // top bit set means null link
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > sllm_pkg::POS_W) ? CNT_W : sllm_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,   // waiting for a command beat
        S_RUN    = 4'b0010,   // store data valid, decide or walk
        S_LINK   = 4'b0100,   // patch the k-th link after an insert
        S_UNLINK = 4'b1000    // bypass the successor on a delete
    } t_state;

    // control state
    t_state                       r_state, n_state;
    logic [LINK_W-1:0]            r_head, n_head;
    logic [CNT_W-1:0]             r_used, n_used;
    logic [sllm_pkg::EMIT_W-1:0]  r_cnt, n_cnt;
    logic                         r_ov;

    // command payload held for the whole operation
    sllm_pkg::t_op                r_op, n_op;
    logic [sllm_pkg::POS_W-1:0]   r_k, n_k;
    logic [sllm_pkg::VAL_W-1:0]   r_val, n_val;
    logic [IDX_W-1:0]             r_at, n_at;

    // result register
    logic [sllm_pkg::VAL_W-1:0]   r_item;
    logic                         r_last;
    sllm_pkg::t_status            r_status;

    // store access
    sllm_pkg::t_mem_ctl           mem_ctl;
    logic [IDX_W-1:0]             rd_addr, lnk_waddr, val_waddr;
    logic [LINK_W-1:0]            lnk_wdata, rd_link;
    logic [sllm_pkg::VAL_W-1:0]   rd_val;

    // result beat being issued this cycle
    logic                         emit;
    logic [sllm_pkg::VAL_W-1:0]   e_val;
    logic                         e_last;
    sllm_pkg::t_status            e_stat;

    logic                         out_free;
    logic                         cmd_fire;
    logic [IDX_W-1:0]             at_in;
    logic                         is_full, k_high, head_nil, link_nil;

    sllm_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_rd_addr   (rd_addr),
        .i_lnk_waddr (lnk_waddr),
        .i_lnk_wdata (lnk_wdata),
        .i_val_waddr (val_waddr),
        .i_val_wdata (r_val),
        .o_rd_link   (rd_link),
        .o_rd_val    (rd_val)
    );

    assign out_free = !r_ov || o_res.ready;
    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // slot of the k-th inserted node
    assign at_in = IDX_W'(CMP_W'(i_cmd.position) - CMP_W'(1));

    assign is_full  = (r_used == CNT_W'(DEPTH));
    assign k_high   = (CMP_W'(r_k) > CMP_W'(r_used));
    assign head_nil = r_head[LINK_W-1];
    assign link_nil = rd_link[LINK_W-1];

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_used    = r_used;
        n_cnt     = r_cnt;
        n_op      = r_op;
        n_k       = r_k;
        n_val     = r_val;
        n_at      = r_at;
        mem_ctl   = '0;
        rd_addr   = '0;
        lnk_waddr = '0;
        lnk_wdata = '0;
        val_waddr = '0;
        emit      = 1'b0;
        e_val     = '0;
        e_last    = 1'b1;
        e_stat    = sllm_pkg::ST_OK;

        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_op  = sllm_pkg::t_op'(i_cmd.operation);
                    n_k   = i_cmd.position;
                    n_val = i_cmd.value;
                    n_at  = at_in;
                    n_cnt = '0;
                    mem_ctl.rd_en = 1'b1;
                    // head for traverse and delete-head, k-th slot otherwise
                    if ((sllm_pkg::t_op'(i_cmd.operation) == sllm_pkg::OP_TRAVERSE) ||
                        ((sllm_pkg::t_op'(i_cmd.operation) == sllm_pkg::OP_DEL_AFTER) &&
                         (i_cmd.position == '0))) begin
                        rd_addr = r_head[IDX_W-1:0];
                    end else begin
                        rd_addr = at_in;
                    end
                    n_state = S_RUN;
                end
            end

            S_RUN: begin
                case (r_op)
                    sllm_pkg::OP_INS_HEAD: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (is_full) begin
                                e_stat = sllm_pkg::ST_FULL;
                            end else begin
                                mem_ctl.val_we = 1'b1;
                                mem_ctl.lnk_we = 1'b1;
                                val_waddr = r_used[IDX_W-1:0];
                                lnk_waddr = r_used[IDX_W-1:0];
                                lnk_wdata = r_head;
                                n_head    = LINK_W'(r_used);
                                n_used    = r_used + CNT_W'(1);
                            end
                            n_state = S_IDLE;
                        end
                    end

                    sllm_pkg::OP_INS_AFTER: begin
                        if (is_full || (r_k == '0) || k_high) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_stat  = is_full ? sllm_pkg::ST_FULL : sllm_pkg::ST_BAD_POS;
                                n_state = S_IDLE;
                            end
                        end else begin
                            // new node takes over the k-th node's successor
                            mem_ctl.val_we = 1'b1;
                            mem_ctl.lnk_we = 1'b1;
                            val_waddr = r_used[IDX_W-1:0];
                            lnk_waddr = r_used[IDX_W-1:0];
                            lnk_wdata = rd_link;
                            n_state   = S_LINK;
                        end
                    end

                    sllm_pkg::OP_DEL_AFTER: begin
                        if (r_k == '0) begin
                            if (out_free) begin
                                emit = 1'b1;
                                if (head_nil) begin
                                    e_stat = sllm_pkg::ST_EMPTY;
                                end else begin
                                    n_head = rd_link;
                                end
                                n_state = S_IDLE;
                            end
                        end else if (k_high || link_nil) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_stat  = k_high ? sllm_pkg::ST_BAD_POS : sllm_pkg::ST_NO_SUCC;
                                n_state = S_IDLE;
                            end
                        end else begin
                            // fetch the successor's own link
                            mem_ctl.rd_en = 1'b1;
                            rd_addr = rd_link[IDX_W-1:0];
                            n_state = S_UNLINK;
                        end
                    end

                    sllm_pkg::OP_TRAVERSE: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (head_nil) begin
                                e_stat  = sllm_pkg::ST_EMPTY;
                                n_state = S_IDLE;
                            end else begin
                                e_val  = rd_val;
                                e_last = link_nil ||
                                         (r_cnt == sllm_pkg::EMIT_W'(sllm_pkg::MAX_RESULTS - 1));
                                n_cnt  = r_cnt + sllm_pkg::EMIT_W'(1);
                                if (e_last) begin
                                    n_state = S_IDLE;
                                end else begin
                                    mem_ctl.rd_en = 1'b1;
                                    rd_addr = rd_link[IDX_W-1:0];
                                end
                            end
                        end
                    end

                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_LINK: begin
                if (out_free) begin
                    mem_ctl.lnk_we = 1'b1;
                    lnk_waddr = r_at;
                    lnk_wdata = LINK_W'(r_used);
                    n_used    = r_used + CNT_W'(1);
                    emit      = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_UNLINK: begin
                if (out_free) begin
                    mem_ctl.lnk_we = 1'b1;
                    lnk_waddr = r_at;
                    lnk_wdata = rd_link;
                    emit      = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '1;
            r_used  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_used  <= n_used;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_k   <= n_k;
        r_val <= n_val;
        r_at  <= n_at;
    end

    // output register: holds a beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_item   <= e_val;
            r_last   <= e_last;
            r_status <= e_stat;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.item_value = r_item;
    assign o_res.last       = r_last;
    assign o_res.status     = r_status;

    // slot count only ever steps up by one
    `SLLM_ASSERT(a_used_step, (i_rst_n && $past(i_rst_n) && (r_used != $past(r_used))) |-> (r_used == $past(r_used) + CNT_W'(1)), "slot count moved by other than one")

    // a live head always names a slot already handed out
    `SLLM_ASSERT(a_head_used, !r_head[LINK_W-1] |-> (CNT_W'(r_head) < r_used), "head names an unused slot")

    // the final beat of a command returns the sequencer to idle
    `SLLM_ASSERT(a_last_idle, (emit && e_last) |=> (r_state == S_IDLE), "sequencer busy after last beat")

endmodule
